@@ hw/rtl/pure_pursuit_goal_point_core_defines.svh @@
// Assertion macros for the goal point core.
// Expects clk and rst in the scope of use.
`ifndef PURE_PURSUIT_GOAL_POINT_CORE_DEFINES_SVH
`define PURE_PURSUIT_GOAL_POINT_CORE_DEFINES_SVH
// same-cycle implication
`define PPGP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PPGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/ppgp_pkg.sv @@
// Shared constants and types of the goal point core.
// No dependencies.
`timescale 1ns / 1ps
package ppgp_pkg;
  localparam int MAX_POINTS = 64;
  localparam int PIDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = PIDX_W + 1;
  localparam int CRD_W      = 24;
  localparam int SPD_W      = 16;
  localparam int RAD_W      = 16;
  localparam int MEM_W      = 2 * CRD_W + SPD_W + RAD_W;

  localparam int MUL_W      = 64;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MUL_CHUNK  = 16;

  localparam int DEN_W      = 2 * CRD_W + 2;
  localparam int NUM_W      = 77;
  localparam int QUO_W      = 32;
  localparam int SOL_CAP    = 2 ** 30;

  localparam int Q_ONE      = 256;
  localparam int Q_TWO_SQ   = 512 * 512;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POSE = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ISECT = 2'd1,
    KIND_END   = 2'd2
  } kind_t;
endpackage

@@ hw/rtl/ppgp_mul.sv @@
// Shared signed multiplier, 64x16 partial product per cycle.
// Depends on ppgp_pkg.
`timescale 1ns / 1ps
module ppgp_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ppgp_pkg::MUL_W-1:0]  a,
  input  logic signed [ppgp_pkg::MUL_W-1:0]  b,
  output logic                                done,
  output logic signed [ppgp_pkg::PROD_W-1:0] p
);
  import ppgp_pkg::*;

  localparam int CHUNKS = MUL_W / MUL_CHUNK;
  localparam int CW     = $clog2(CHUNKS);

  logic [MUL_W-1:0]  am;
  logic [MUL_W-1:0]  bm;
  logic [PROD_W-1:0] acc;
  logic              neg;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy && !fin) begin
        am   <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
        bm   <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
        acc  <= '0;
        neg  <= a[MUL_W-1] ^ b[MUL_W-1];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= (acc << MUL_CHUNK) + PROD_W'(am * bm[MUL_W-1 -: MUL_CHUNK]);
        bm  <= bm << MUL_CHUNK;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(CHUNKS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        p    <= neg ? PROD_W'(-acc) : PROD_W'(acc);
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

@@ hw/rtl/ppgp_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating, capped quotient.
// Depends on ppgp_pkg.
`timescale 1ns / 1ps
module ppgp_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ppgp_pkg::NUM_W-1:0] num,
  input  logic        [ppgp_pkg::DEN_W-1:0] den,
  output logic                               done,
  output logic signed [ppgp_pkg::QUO_W-1:0] quo
);
  import ppgp_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] m;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             fin;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [QUO_W-2:0] qc;

  assign rem_sh = {rem, m[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dv};
  assign qc     = (q > NUM_W'(SOL_CAP)) ? (QUO_W-1)'(SOL_CAP) : q[QUO_W-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy && !fin) begin
        m    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        neg  <= num[NUM_W-1];
        dv   <= den;
        rem  <= '0;
        q    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? DEN_W'(rem_sh - {1'b0, dv}) : DEN_W'(rem_sh);
        q   <= {q[NUM_W-2:0], ge};
        m   <= m << 1;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        quo  <= neg ? -QUO_W'({1'b0, qc}) : QUO_W'({1'b0, qc});
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

@@ hw/rtl/pure_pursuit_goal_point_core.sv @@
// Pure pursuit goal point core: path memory plus serial segment walker.
// Load item: writes the point and goes straight to S_EMIT. Pose item: reads the path, then per walked
// segment skips a repeated point, checks the first products (no intersection) or runs a full solve;
// up to MAX_POINTS-1 segments. The 77-step divider, 42-step square root and the shared
// 64x16 multiplier set the per-segment time. One item at a time.
// Reset clears progress, path_points and the handshakes; the path memory is not cleared.
`timescale 1ns / 1ps
`include "pure_pursuit_goal_point_core_defines.svh"
module pure_pursuit_goal_point_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [ppgp_pkg::CNT_W-1:0]  cfg_data,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic                               cmd,
  input  logic        [ppgp_pkg::PIDX_W-1:0] point_index,
  input  logic signed [ppgp_pkg::CRD_W-1:0]  point_x,
  input  logic signed [ppgp_pkg::CRD_W-1:0]  point_y,
  input  logic        [ppgp_pkg::SPD_W-1:0]  point_speed,
  input  logic        [ppgp_pkg::RAD_W-1:0]  point_lookahead,
  input  logic signed [ppgp_pkg::CRD_W-1:0]  robot_x,
  input  logic signed [ppgp_pkg::CRD_W-1:0]  robot_y,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [ppgp_pkg::CRD_W-1:0]  goal_x,
  output logic signed [ppgp_pkg::CRD_W-1:0]  goal_y,
  output logic        [ppgp_pkg::SPD_W-1:0]  goal_speed,
  output logic        [ppgp_pkg::RAD_W-1:0]  goal_lookahead,
  output logic        [ppgp_pkg::PIDX_W-1:0] segment_index,
  output logic        [1:0]                  goal_kind
);
  import ppgp_pkg::*;

  localparam int REL_W  = CRD_W + 1;
  localparam int SQR_W  = 2 * CRD_W + 1;
  localparam int XP_W   = 2 * CRD_W + 2;
  localparam int DD_W   = XP_W + 1;
  localparam int R2_W   = 2 * RAD_W;
  localparam int RD_W   = R2_W + DEN_W;
  localparam int DD2_W  = 2 * (DD_W - 1);
  localparam int DISC_W = DD2_W + 1;
  localparam int SQ_W   = 42;
  localparam int RAD2_W = 2 * SQ_W;
  localparam int SREM_W = SQ_W + 2;
  localparam int SCNT_W = $clog2(SQ_W);
  localparam int T_W    = NUM_W - 1;
  localparam int SUM_W  = QUO_W + 1;
  localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'(2 ** (CRD_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] C_MIN = SUM_W'(-(2 ** (CRD_W - 1)));

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_QCHK = 13'b0000000000010,
    S_RDA  = 13'b0000000000100,
    S_RDB  = 13'b0000000001000,
    S_LDB  = 13'b0000000010000,
    S_MUL  = 13'b0000000100000,
    S_CHK  = 13'b0000001000000,
    S_SQRT = 13'b0000010000000,
    S_DIV  = 13'b0000100000000,
    S_SEL  = 13'b0001000000000,
    S_BRK  = 13'b0010000000000,
    S_NEXT = 13'b0100000000000,
    S_EMIT = 13'b1000000000000
  } state_t;

  typedef enum logic [4:0] {
    M_EX2, M_EY2, M_DX2, M_DY2, M_X1Y2, M_X2Y1, M_R2, M_RD, M_DD,
    M_T1, M_T2, M_U1, M_U2, M_G1, M_G2, M_B1, M_B2
  } mop_t;

  function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [SUM_W-1:0] v);
    if (v > C_MAX) return C_MAX[CRD_W-1:0];
    if (v < C_MIN) return C_MIN[CRD_W-1:0];
    return v[CRD_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] mag_d(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  function automatic logic [REL_W-1:0] mag_r(input logic signed [REL_W-1:0] v);
    return v[REL_W-1] ? REL_W'(-v) : REL_W'(v);
  endfunction

  state_t st;
  mop_t   mop;

  logic [CNT_W-1:0]  path_points;
  logic [CNT_W-1:0]  n_pts;
  logic [CNT_W-1:0]  seg_i;
  logic [PIDX_W-1:0] progress;

  logic signed [CRD_W-1:0] rx, ry, end_x, end_y, ax, ay, bx, by, gx, gy;
  logic [SPD_W-1:0] b_spd, gs;
  logic [RAD_W-1:0] b_rad, gl;
  kind_t            kind;

  logic [MEM_W-1:0]  path_mem [MAX_POINTS];
  logic [MEM_W-1:0]  rd_data;
  logic [PIDX_W-1:0] rd_addr;
  logic              mem_re;
  logic              mem_we;
  logic signed [CRD_W-1:0] rd_x, rd_y;
  logic [SPD_W-1:0]        rd_spd;
  logic [RAD_W-1:0]        rd_rad;

  logic signed [REL_W-1:0] ex, ey, dx, dy, x1, y1, x2, y2, gdx, gdy, sdx;
  logic [REL_W-1:0]        dy_mag;

  logic [SQR_W-1:0]        p_ex2, p_ey2, p_dx2, p_dy2, p_g1, p_g2, p_b1, p_b2;
  logic signed [XP_W-1:0]  p_x1y2, p_x2y1;
  logic [R2_W-1:0]         p_r2;
  logic [RD_W-1:0]         p_rd;
  logic [DD2_W-1:0]        p_dd2;
  logic signed [T_W-1:0]   t1, t2, u1, u2;
  logic signed [DD_W-1:0]  dd;
  logic [DEN_W-1:0]        dr2, de2;
  logic signed [DISC_W-1:0] disc;

  logic [RAD2_W-1:0] sq_rad;
  logic [SREM_W-1:0] sq_rem;
  logic [SQ_W-1:0]   sq_root;
  logic [SCNT_W-1:0] sq_cnt;
  logic [SREM_W-1:0] sq_sh;
  logic [SREM_W-1:0] sq_trial;

  logic                       mul_start, mul_done, mul_issued;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;

  logic                       div_start, div_issued;
  logic [3:0]                 div_done;
  logic signed [NUM_W-1:0]    n_x1, n_x2, n_y1, n_y2;
  logic signed [QUO_W-1:0]    xs1, xs2, ys1, ys2;

  logic signed [CRD_W-1:0] s1x, s1y, s2x, s2y, mnx, mxx, mny, mxy;
  logic                    v1, v2, take2, near_end;
  logic [RAD_W-1:0]        gl_cur;
  logic                    item_acc;

  assign cfg_ready  = 1'b1;
  assign item_ready = (st == S_IDLE);
  assign item_acc   = item_valid && item_ready;
  assign mem_we     = item_acc && (cmd == CMD_LOAD) &&
                      ({1'b0, point_index} < CNT_W'(MAX_POINTS));

  assign rd_x   = rd_data[MEM_W-1 -: CRD_W];
  assign rd_y   = rd_data[MEM_W-CRD_W-1 -: CRD_W];
  assign rd_spd = rd_data[RAD_W+SPD_W-1 -: SPD_W];
  assign rd_rad = rd_data[RAD_W-1:0];

  always_comb begin
    mem_re  = 1'b1;
    rd_addr = '0;
    case (st)
      S_QCHK:  rd_addr = PIDX_W'(n_pts - CNT_W'(1));
      S_RDA:   rd_addr = seg_i[PIDX_W-1:0];
      S_RDB:   rd_addr = PIDX_W'(seg_i + CNT_W'(1));
      S_NEXT:  rd_addr = PIDX_W'(seg_i + CNT_W'(2));
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      path_mem[point_index] <= {point_x, point_y, point_speed, point_lookahead};
    end
    if (mem_re) begin
      rd_data <= path_mem[rd_addr];
    end
  end

  assign ex  = REL_W'(end_x) - REL_W'(rx);
  assign ey  = REL_W'(end_y) - REL_W'(ry);
  assign dx  = REL_W'(bx) - REL_W'(ax);
  assign dy  = REL_W'(by) - REL_W'(ay);
  assign x1  = REL_W'(ax) - REL_W'(rx);
  assign y1  = REL_W'(ay) - REL_W'(ry);
  assign x2  = REL_W'(bx) - REL_W'(rx);
  assign y2  = REL_W'(by) - REL_W'(ry);
  assign gdx = REL_W'(gx) - REL_W'(bx);
  assign gdy = REL_W'(gy) - REL_W'(by);
  assign sdx = dy[REL_W-1] ? -dx : dx;
  assign dy_mag = mag_r(dy);

  assign dd   = DD_W'(p_x1y2) - DD_W'(p_x2y1);
  assign dr2  = DEN_W'(p_dx2) + DEN_W'(p_dy2);
  assign de2  = DEN_W'(p_ex2) + DEN_W'(p_ey2);
  assign disc = DISC_W'(p_rd) - DISC_W'(p_dd2);
  assign near_end = (mag_r(ex) <= REL_W'(Q_ONE) && mag_r(ey) <= REL_W'(Q_ONE)) ||
                    (de2 <= DEN_W'(Q_TWO_SQ));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mop)
      M_EX2:   begin mul_a = MUL_W'(ex);     mul_b = MUL_W'(ex);      end
      M_EY2:   begin mul_a = MUL_W'(ey);     mul_b = MUL_W'(ey);      end
      M_DX2:   begin mul_a = MUL_W'(dx);     mul_b = MUL_W'(dx);      end
      M_DY2:   begin mul_a = MUL_W'(dy);     mul_b = MUL_W'(dy);      end
      M_X1Y2:  begin mul_a = MUL_W'(x1);     mul_b = MUL_W'(y2);      end
      M_X2Y1:  begin mul_a = MUL_W'(x2);     mul_b = MUL_W'(y1);      end
      M_R2:    begin mul_a = MUL_W'(b_rad);  mul_b = MUL_W'(b_rad);   end
      M_RD:    begin mul_a = MUL_W'(p_r2);   mul_b = MUL_W'(dr2);     end
      M_DD:    begin mul_a = MUL_W'(dd);     mul_b = MUL_W'(dd);      end
      M_T1:    begin mul_a = MUL_W'(dd);     mul_b = MUL_W'(dy);      end
      M_T2:    begin mul_a = MUL_W'(sdx);    mul_b = MUL_W'(sq_root); end
      M_U1:    begin mul_a = -MUL_W'(dd);    mul_b = MUL_W'(dx);      end
      M_U2:    begin mul_a = MUL_W'(dy_mag); mul_b = MUL_W'(sq_root); end
      M_G1:    begin mul_a = MUL_W'(gdx);    mul_b = MUL_W'(gdx);     end
      M_G2:    begin mul_a = MUL_W'(gdy);    mul_b = MUL_W'(gdy);     end
      M_B1:    begin mul_a = MUL_W'(x2);     mul_b = MUL_W'(x2);      end
      M_B2:    begin mul_a = MUL_W'(y2);     mul_b = MUL_W'(y2);      end
      default: begin mul_a = '0;             mul_b = '0;              end
    endcase
  end

  assign mul_start = (st == S_MUL) && !mul_issued;

  ppgp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign n_x1 = NUM_W'(t1) + NUM_W'(t2);
  assign n_x2 = NUM_W'(t1) - NUM_W'(t2);
  assign n_y1 = NUM_W'(u1) + NUM_W'(u2);
  assign n_y2 = NUM_W'(u1) - NUM_W'(u2);
  assign div_start = (st == S_DIV) && !div_issued;

  ppgp_div u_div_x1 (.clk(clk), .rst(rst), .start(div_start), .num(n_x1), .den(dr2),
                     .done(div_done[0]), .quo(xs1));
  ppgp_div u_div_x2 (.clk(clk), .rst(rst), .start(div_start), .num(n_x2), .den(dr2),
                     .done(div_done[1]), .quo(xs2));
  ppgp_div u_div_y1 (.clk(clk), .rst(rst), .start(div_start), .num(n_y1), .den(dr2),
                     .done(div_done[2]), .quo(ys1));
  ppgp_div u_div_y2 (.clk(clk), .rst(rst), .start(div_start), .num(n_y2), .den(dr2),
                     .done(div_done[3]), .quo(ys2));

  assign sq_sh    = {sq_rem[SREM_W-3:0], sq_rad[RAD2_W-1 -: 2]};
  assign sq_trial = {sq_root, 2'b01};

  assign s1x = sat_crd(SUM_W'(xs1) + SUM_W'(rx));
  assign s1y = sat_crd(SUM_W'(ys1) + SUM_W'(ry));
  assign s2x = sat_crd(SUM_W'(xs2) + SUM_W'(rx));
  assign s2y = sat_crd(SUM_W'(ys2) + SUM_W'(ry));
  assign mnx = (ax < bx) ? ax : bx;
  assign mxx = (ax < bx) ? bx : ax;
  assign mny = (ay < by) ? ay : by;
  assign mxy = (ay < by) ? by : ay;
  assign v1  = mnx <= s1x && s1x <= mxx && mny <= s1y && s1y <= mxy;
  assign v2  = mnx <= s2x && s2x <= mxx && mny <= s2y && s2y <= mxy;
  assign gl_cur = v1 ? b_rad : gl;
  assign take2  = v2 && (gl_cur == '0 ||
                  mag_d(SUM_W'(xs1) - SUM_W'(x2)) > mag_d(SUM_W'(xs2) - SUM_W'(x2)) ||
                  mag_d(SUM_W'(ys1) - SUM_W'(y2)) > mag_d(SUM_W'(ys2) - SUM_W'(y2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      mop          <= M_EX2;
      path_points  <= '0;
      progress     <= '0;
      mul_issued   <= 1'b0;
      div_issued   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        path_points <= cfg_data;
      end
      if (st == S_EMIT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (item_acc) begin
            gx   <= '0;
            gy   <= '0;
            gs   <= '0;
            gl   <= '0;
            kind <= KIND_NONE;
            if (cmd == CMD_LOAD) begin
              if (point_index == '0) begin
                progress <= '0;
              end
              st <= S_EMIT;
            end else begin
              rx    <= robot_x;
              ry    <= robot_y;
              n_pts <= (path_points > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : path_points;
              seg_i <= CNT_W'(progress);
              st    <= S_QCHK;
            end
          end
        end
        S_QCHK: begin
          if (n_pts < CNT_W'(2) || CNT_W'(progress) + CNT_W'(1) >= n_pts) begin
            st <= S_EMIT;
          end else begin
            st <= S_RDA;
          end
        end
        S_RDA: begin
          end_x <= rd_x;
          end_y <= rd_y;
          st    <= S_RDB;
        end
        S_RDB: begin
          ax <= rd_x;
          ay <= rd_y;
          st <= S_LDB;
        end
        S_LDB: begin
          bx    <= rd_x;
          by    <= rd_y;
          b_spd <= rd_spd;
          b_rad <= rd_rad;
          if (rd_x == ax && rd_y == ay) begin
            st <= S_NEXT;
          end else begin
            mop <= M_EX2;
            st  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_start) begin
            mul_issued <= 1'b1;
          end
          if (mul_done) begin
            mul_issued <= 1'b0;
            case (mop)
              M_EX2:  begin p_ex2  <= mul_p[SQR_W-1:0]; mop <= M_EY2;  end
              M_EY2:  begin p_ey2  <= mul_p[SQR_W-1:0]; mop <= M_DX2;  end
              M_DX2:  begin p_dx2  <= mul_p[SQR_W-1:0]; mop <= M_DY2;  end
              M_DY2:  begin p_dy2  <= mul_p[SQR_W-1:0]; mop <= M_X1Y2; end
              M_X1Y2: begin p_x1y2 <= mul_p[XP_W-1:0];  mop <= M_X2Y1; end
              M_X2Y1: begin p_x2y1 <= mul_p[XP_W-1:0];  mop <= M_R2;   end
              M_R2:   begin p_r2   <= mul_p[R2_W-1:0];  mop <= M_RD;   end
              M_RD:   begin p_rd   <= mul_p[RD_W-1:0];  mop <= M_DD;   end
              M_DD:   begin p_dd2  <= mul_p[DD2_W-1:0]; st  <= S_CHK;  end
              M_T1:   begin t1     <= mul_p[T_W-1:0];   mop <= M_T2;   end
              M_T2:   begin t2     <= mul_p[T_W-1:0];   mop <= M_U1;   end
              M_U1:   begin u1     <= mul_p[T_W-1:0];   mop <= M_U2;   end
              M_U2:   begin u2     <= mul_p[T_W-1:0];   st  <= S_DIV;  end
              M_G1:   begin p_g1   <= mul_p[SQR_W-1:0]; mop <= M_G2;   end
              M_G2:   begin p_g2   <= mul_p[SQR_W-1:0]; mop <= M_B1;   end
              M_B1:   begin p_b1   <= mul_p[SQR_W-1:0]; mop <= M_B2;   end
              M_B2:   begin p_b2   <= mul_p[SQR_W-1:0]; st  <= S_BRK;  end
              default: st <= S_EMIT;
            endcase
          end
        end
        S_CHK: begin
          if (disc[DISC_W-1]) begin
            st <= S_NEXT;
          end else if (near_end) begin
            gx   <= '0;
            gy   <= '0;
            gs   <= '0;
            gl   <= '0;
            kind <= KIND_NONE;
            st   <= S_EMIT;
          end else if (de2 <= DEN_W'(p_r2)) begin
            gx   <= end_x;
            gy   <= end_y;
            gs   <= b_spd;
            gl   <= b_rad;
            kind <= KIND_END;
            st   <= S_EMIT;
          end else begin
            sq_rad  <= disc[RAD2_W-1:0];
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= '0;
            st      <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_rad <= sq_rad << 2;
          if (sq_sh >= sq_trial) begin
            sq_rem  <= sq_sh - sq_trial;
            sq_root <= {sq_root[SQ_W-2:0], 1'b1};
          end else begin
            sq_rem  <= sq_sh;
            sq_root <= {sq_root[SQ_W-2:0], 1'b0};
          end
          sq_cnt <= sq_cnt + SCNT_W'(1);
          if (sq_cnt == SCNT_W'(SQ_W - 1)) begin
            mop <= M_T1;
            st  <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_start) begin
            div_issued <= 1'b1;
          end
          if (&div_done) begin
            div_issued <= 1'b0;
            st         <= S_SEL;
          end
        end
        S_SEL: begin
          if (take2) begin
            gx   <= s2x;
            gy   <= s2y;
            gs   <= b_spd;
            gl   <= b_rad;
            kind <= KIND_ISECT;
          end else if (v1) begin
            gx   <= s1x;
            gy   <= s1y;
            gs   <= b_spd;
            gl   <= b_rad;
            kind <= KIND_ISECT;
          end
          if (v1 || v2) begin
            mop <= M_G1;
            st  <= S_MUL;
          end else begin
            st <= S_NEXT;
          end
        end
        S_BRK: begin
          // goal nearer the far point than the robot: stop the walk
          if (DEN_W'(p_g1) + DEN_W'(p_g2) < DEN_W'(p_b1) + DEN_W'(p_b2)) begin
            st <= S_EMIT;
          end else begin
            progress <= progress + PIDX_W'(1);
            st       <= S_NEXT;
          end
        end
        S_NEXT: begin
          seg_i <= seg_i + CNT_W'(1);
          ax    <= bx;
          ay    <= by;
          if (seg_i + CNT_W'(2) < n_pts) begin
            st <= S_LDB;
          end else begin
            st <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            goal_x         <= gx;
            goal_y         <= gy;
            goal_speed     <= gs;
            goal_lookahead <= gl;
            goal_kind      <= kind;
            segment_index  <= progress;
            st             <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `PPGP_ASSERT_NEXT(a_item_starts_work, item_valid && item_ready, st != S_IDLE,
                    "item taken but sequencer stayed idle")
  `PPGP_ASSERT_SAME(a_mul_owned, mul_done, st == S_MUL && mul_issued,
                    "product returned outside a multiply step")
  `PPGP_ASSERT_SAME(a_none_is_zero, result_valid && goal_kind == KIND_NONE,
                    goal_x == '0 && goal_y == '0 && goal_lookahead == '0,
                    "kind none with nonzero goal")
endmodule
